>>> hw/rtl/avp_pkg.sv
// Shared types, ASCII codes and a digit helper for the voltage/power field parser.
package avp_pkg;

   localparam int WinLen = 11;
   localparam int ByteW  = 8;
   localparam int ValueW = 23;
   localparam int CountW = 32;
   localparam int FillW  = 4;

   typedef logic [ByteW-1:0]         byte_type;
   typedef logic signed [ValueW-1:0] value_type;
   typedef logic [CountW-1:0]        count_type;
   typedef logic [FillW-1:0]         fill_type;

   typedef enum logic {
      KindVoltage = 1'b0,
      KindPower   = 1'b1
   } kind_type;

   localparam fill_type FillFull = FillW'(WinLen);

   localparam byte_type AsciiUpperV = 8'd86;
   localparam byte_type AsciiLowerO = 8'd111;
   localparam byte_type AsciiUpperP = 8'd80;
   localparam byte_type AsciiLowerS = 8'd115;
   localparam byte_type AsciiDot    = 8'd46;
   localparam byte_type AsciiSpace  = 8'd32;
   localparam byte_type AsciiCr     = 8'd13;
   localparam byte_type AsciiLf     = 8'd10;
   localparam byte_type AsciiZero   = 8'd48;

   localparam value_type Weight1e4 = 23'sd10000;
   localparam value_type Weight1e3 = 23'sd1000;
   localparam value_type Weight1e2 = 23'sd100;
   localparam value_type Weight1e1 = 23'sd10;

   // Byte minus the code of '0', with no check that the byte is a digit.
   function automatic value_type digit_val(input byte_type b);
      value_type ext;
      ext = value_type'(b);
      return ext - value_type'(AsciiZero);
   endfunction

endpackage

>>> hw/rtl/avp_req_if.sv
// Receive byte channel: one UART byte and its end-of-burst mark per transaction.
interface avp_req_if;
   logic                valid;
   logic                ready;
   avp_pkg::byte_type   rx_byte;
   logic                burst_end;

   modport source (output valid, output rx_byte, output burst_end, input ready);
   modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

>>> hw/rtl/avp_rsp_if.sv
// Result channel: one parsed field value and its match count per transaction.
interface avp_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 value_kind;
   avp_pkg::value_type   value_hundredths;
   avp_pkg::count_type   match_count;

   modport source (output valid, output value_kind, output value_hundredths,
                   output match_count, input ready);
   modport sink   (input valid, input value_kind, input value_hundredths,
                   input match_count, output ready);
endinterface

>>> hw/rtl/ascii_voltage_power_field_parser_core.sv
// Throughput: one byte per cycle while the result side takes each result.
// The window register is the input stage; the field match and digit sum sit
// between it and the result register, so the result register sets the pace.
// Reset (synchronous, active high) empties the window and clears both match
// counters and all valid flags; window bytes are not cleared.
module ascii_voltage_power_field_parser_core (
   input  logic               clock,
   input  logic               reset,
   avp_req_if.sink            req,
   avp_rsp_if.source          rsp
);

   // Sliding window, entry 0 is the oldest byte. It is the input register of
   // the single processing stage: it holds the window as it stands after the
   // accepted byte has been shifted in.
   avp_pkg::byte_type  win_ff [avp_pkg::WinLen];
   avp_pkg::fill_type  fill_ff, fill_in, fill_sat;

   // Stage flags: a transaction is pending evaluation, and whether its window
   // was full once its byte had been shifted in.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_eval_ff, s1_eval_in;

   // Running match counters per field kind.
   avp_pkg::count_type volt_ff, volt_in;
   avp_pkg::count_type power_ff, power_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   avp_pkg::kind_type  kind_ff, kind_in;
   avp_pkg::value_type value_ff, value_in;
   avp_pkg::count_type count_ff, count_in;

   logic               req_take;
   logic               s1_adv;
   logic               rsp_free;

   // Field decode results.
   logic               volt_anchor, power_anchor;
   logic               hit;
   logic               bump_volt, bump_power;
   avp_pkg::kind_type  hit_kind;
   avp_pkg::value_type hit_value;
   avp_pkg::value_type d3, d4, d5, d6, d7, d8;

   // The result register can load when it is empty or is being emptied now.
   // The stage always moves on under that condition, whether or not the
   // window produces a result, so a new byte can enter in the same cycle.
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && rsp_free;
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_take  = req.valid && req.ready;

   // Fill count saturates at the window length; the end-of-burst mark empties
   // the window only after its own byte has been evaluated.
   always_comb begin
      fill_sat = (fill_ff == avp_pkg::FillFull) ? fill_ff
                                                : fill_ff + avp_pkg::fill_type'(1);
      fill_in  = fill_ff;
      s1_eval_in = s1_eval_ff;
      if (req_take) begin
         fill_in    = req.burst_end ? '0 : fill_sat;
         s1_eval_in = (fill_sat == avp_pkg::FillFull);
      end
      s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < avp_pkg::WinLen - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[avp_pkg::WinLen-1] <= req.rx_byte;
      end
   end

   // Digit slots as signed values (no digit check).
   assign d3 = avp_pkg::digit_val(win_ff[3]);
   assign d4 = avp_pkg::digit_val(win_ff[4]);
   assign d5 = avp_pkg::digit_val(win_ff[5]);
   assign d6 = avp_pkg::digit_val(win_ff[6]);
   assign d7 = avp_pkg::digit_val(win_ff[7]);
   assign d8 = avp_pkg::digit_val(win_ff[8]);

   assign volt_anchor  = (win_ff[0] == avp_pkg::AsciiUpperV) &&
                         (win_ff[1] == avp_pkg::AsciiLowerO);
   assign power_anchor = (win_ff[0] == avp_pkg::AsciiUpperP) &&
                         (win_ff[1] == avp_pkg::AsciiLowerS);

   // Forms are tried in a fixed order and the first fit wins. Byte 2 follows
   // the anchor and is always skipped. Only the two-digit power form advances the
   // power counter; the other power forms report the count as it stands.
   always_comb begin
      hit        = 1'b0;
      bump_volt  = 1'b0;
      bump_power = 1'b0;
      hit_kind   = avp_pkg::KindVoltage;
      hit_value  = '0;
      if (s1_eval_ff) begin
         priority if (volt_anchor) begin
            priority if (win_ff[5] == avp_pkg::AsciiDot &&
                         win_ff[8] == avp_pkg::AsciiSpace) begin
               hit       = 1'b1;
               bump_volt = 1'b1;
               hit_value = d3 * avp_pkg::Weight1e3 + d4 * avp_pkg::Weight1e2 +
                           d6 * avp_pkg::Weight1e1 + d7;
            end else if (win_ff[4] == avp_pkg::AsciiDot &&
                         win_ff[7] == avp_pkg::AsciiSpace) begin
               // Short voltage form: units, tenths and hundredths, no tens digit.
               hit       = 1'b1;
               bump_volt = 1'b1;
               hit_value = d3 * avp_pkg::Weight1e2 + d5 * avp_pkg::Weight1e1 + d6;
            end else begin
               hit = 1'b0;
            end
         end else if (power_anchor) begin
            hit_kind = avp_pkg::KindPower;
            priority if (win_ff[5] == avp_pkg::AsciiDot &&
                         win_ff[8] == avp_pkg::AsciiCr &&
                         win_ff[9] == avp_pkg::AsciiLf) begin
               hit        = 1'b1;
               bump_power = 1'b1;
               hit_value  = d3 * avp_pkg::Weight1e3 + d4 * avp_pkg::Weight1e2 +
                            d6 * avp_pkg::Weight1e1 + d7;
            end else if (win_ff[6] == avp_pkg::AsciiDot &&
                         win_ff[9] == avp_pkg::AsciiCr &&
                         win_ff[10] == avp_pkg::AsciiLf) begin
               hit       = 1'b1;
               hit_value = d3 * avp_pkg::Weight1e4 + d4 * avp_pkg::Weight1e3 +
                           d5 * avp_pkg::Weight1e2 + d7 * avp_pkg::Weight1e1 + d8;
            end else if (win_ff[4] == avp_pkg::AsciiDot &&
                         win_ff[7] == avp_pkg::AsciiCr &&
                         win_ff[8] == avp_pkg::AsciiLf) begin
               hit       = 1'b1;
               hit_value = d3 * avp_pkg::Weight1e2 + d5 * avp_pkg::Weight1e1 + d6;
            end else begin
               hit = 1'b0;
            end
         end else begin
            hit = 1'b0;
         end
      end
   end

   // Counters and the result register load together when the stage advances with a hit.
   always_comb begin
      volt_in      = volt_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      if (s1_adv && hit) begin
         if (bump_volt) begin
            volt_in = volt_ff + avp_pkg::count_type'(1);
         end
         if (bump_power) begin
            power_in = power_ff + avp_pkg::count_type'(1);
         end
         rsp_valid_in = 1'b1;
         kind_in      = hit_kind;
         value_in     = hit_value;
         count_in     = (hit_kind == avp_pkg::KindPower) ? power_in : volt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s1_eval_ff   <= 1'b0;
         volt_ff      <= '0;
         power_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         s1_eval_ff   <= s1_eval_in;
         volt_ff      <= volt_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.value_kind       = kind_ff;
   assign rsp.value_hundredths = value_ff;
   assign rsp.match_count      = count_ff;

   // The fill count never passes the window length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= avp_pkg::FillFull)
      else $error("window fill count beyond window length");

   // The input side stalls only behind a result that is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp.ready))
      else $error("input stalled without a held result");

   // A voltage result carries the incremented voltage count.
   a_volt_count: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && hit && hit_kind == avp_pkg::KindVoltage)
      |=> (volt_ff == $past(volt_ff) + avp_pkg::count_type'(1)) &&
          (rsp.match_count == volt_ff))
      else $error("voltage count not advanced with its result");

   // The power counter never moves without a power result being loaded.
   a_power_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && hit && hit_kind == avp_pkg::KindPower) |=> $stable(power_ff))
      else $error("power count changed without a power match");

endmodule

>>> tb/tb_ascii_voltage_power_field_parser_core.sv
// Self-checking testbench for the ASCII voltage/power field parser core.
module tb_ascii_voltage_power_field_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is short: about nine hundred bytes, each waiting out random idle
   // gaps and result-side stalls. The limit leaves a wide margin on top.
   localparam int CycleLimit  = 200000;
   localparam int RandomBytes = 800;
   localparam int DrainCycles = 8;
   localparam int IdlePercent = 13;
   localparam int QuietFrom   = 400;
   localparam int QuietTo     = 650;

   // Field layouts that a frame can carry after its anchor and separator.
   typedef enum int {
      FormVoltLong,
      FormVoltShort,
      FormPowerTwo,
      FormPowerThree,
      FormPowerOne
   } form_type;

   // How the digit slots of a frame are filled.
   typedef enum int {
      DigitsDecimal,
      DigitsWild,
      DigitsLowByte,
      DigitsHighByte
   } digit_mode_type;

   typedef avp_pkg::byte_type frame_type [avp_pkg::WinLen];

   typedef struct packed {
      avp_pkg::kind_type  kind;
      avp_pkg::value_type value;
      avp_pkg::count_type count;
   } field_result_type;

   // The scoreboard mirrors the parser: the same sliding window, the same fill
   // level and the same two match counters. Every accepted byte is pushed
   // through it, and whatever field it recognizes is queued for the result
   // side to confirm in order.
   class field_scoreboard;
      avp_pkg::byte_type  window [avp_pkg::WinLen];
      int unsigned        fill;
      avp_pkg::count_type voltage_total;
      avp_pkg::count_type power_total;
      field_result_type   awaited [$];
      int unsigned        errors;

      function new();
         fill          = 0;
         voltage_total = '0;
         power_total   = '0;
         errors        = 0;
         foreach (window[i]) window[i] = '0;
      endfunction

      // A digit slot is taken as the raw byte minus the code of zero, so
      // non-digits simply give out-of-range weights.
      function int digit(int unsigned pos);
         return int'(window[pos]) - int'(avp_pkg::AsciiZero);
      endfunction

      function void queue_field(avp_pkg::kind_type kind, int value,
                                avp_pkg::count_type count);
         field_result_type r;
         r.kind  = kind;
         r.value = avp_pkg::value_type'(value);
         r.count = count;
         awaited.push_back(r);
      endfunction

      function void note_input(avp_pkg::byte_type rx, logic last);
         for (int i = 0; i < avp_pkg::WinLen - 1; i++) window[i] = window[i + 1];
         window[avp_pkg::WinLen - 1] = rx;
         if (fill < avp_pkg::WinLen) fill++;

         // Only a full window is examined; the anchor sits in the two oldest
         // bytes and the forms are tried in a fixed order, first hit wins.
         if (fill == avp_pkg::WinLen) begin
            if (window[0] == avp_pkg::AsciiUpperV &&
                window[1] == avp_pkg::AsciiLowerO) begin
               if (window[5] == avp_pkg::AsciiDot &&
                   window[8] == avp_pkg::AsciiSpace) begin
                  voltage_total++;
                  queue_field(avp_pkg::KindVoltage, digit(3) * 1000 + digit(4) * 100 +
                              digit(6) * 10 + digit(7), voltage_total);
               end else if (window[4] == avp_pkg::AsciiDot &&
                            window[7] == avp_pkg::AsciiSpace) begin
                  // The short form carries no tens digit at all.
                  voltage_total++;
                  queue_field(avp_pkg::KindVoltage, digit(3) * 100 + digit(5) * 10 +
                              digit(6), voltage_total);
               end
            end else if (window[0] == avp_pkg::AsciiUpperP &&
                         window[1] == avp_pkg::AsciiLowerS) begin
               if (window[5] == avp_pkg::AsciiDot && window[8] == avp_pkg::AsciiCr &&
                   window[9] == avp_pkg::AsciiLf) begin
                  power_total++;
                  queue_field(avp_pkg::KindPower, digit(3) * 1000 + digit(4) * 100 +
                              digit(6) * 10 + digit(7), power_total);
               end else if (window[6] == avp_pkg::AsciiDot &&
                            window[9] == avp_pkg::AsciiCr &&
                            window[10] == avp_pkg::AsciiLf) begin
                  // The three-digit and one-digit power forms leave the
                  // power count where it is.
                  queue_field(avp_pkg::KindPower, digit(3) * 10000 + digit(4) * 1000 +
                              digit(5) * 100 + digit(7) * 10 + digit(8),
                              power_total);
               end else if (window[4] == avp_pkg::AsciiDot &&
                            window[7] == avp_pkg::AsciiCr &&
                            window[8] == avp_pkg::AsciiLf) begin
                  queue_field(avp_pkg::KindPower, digit(3) * 100 + digit(5) * 10 +
                              digit(6), power_total);
               end
            end
         end

         // The end of a burst is handled after the byte has been examined.
         if (last) fill = 0;
      endfunction

      function void check_result(logic kind, avp_pkg::value_type value,
                                 avp_pkg::count_type count);
         field_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with none awaited: kind %0d value %0d count %0d",
                     $time, kind, value, count);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (kind !== want.kind) begin
            $display("%0t: value_kind mismatch: expected %0d actual %0d",
                     $time, want.kind, kind);
            errors++;
         end
         if (value !== want.value) begin
            $display("%0t: value_hundredths mismatch: expected %0d actual %0d",
                     $time, want.value, value);
            errors++;
         end
         if (count !== want.count) begin
            $display("%0t: match_count mismatch: expected %0d actual %0d",
                     $time, want.count, count);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   bit              idle_on = 1'b1;
   int unsigned     sent_bytes = 0;
   int unsigned     cycle_count = 0;
   field_scoreboard board;

   avp_req_if req_ch ();
   avp_rsp_if rsp_ch ();

   ascii_voltage_power_field_parser_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The result side stalls at random, except during the quiet stretch in
   // the middle of the random part, where it takes every result at once.
   always @(posedge clock) begin
      rsp_ch.ready <= !(idle_on && $urandom_range(99) < IdlePercent);
   end

   // Both monitors run in one block so that a result is always checked
   // before the byte accepted at the same edge is pushed into the
   // predictor; a byte's result can only appear at a later edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_result(rsp_ch.value_kind, rsp_ch.value_hundredths,
                               rsp_ch.match_count);
         end
         if (req_ch.valid && req_ch.ready) begin
            board.note_input(req_ch.rx_byte, req_ch.burst_end);
         end
      end
   end

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycle_count, board.awaited.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic avp_pkg::byte_type pick_digit(digit_mode_type mode);
      case (mode)
         DigitsDecimal:  return avp_pkg::AsciiZero + avp_pkg::byte_type'($urandom_range(9));
         DigitsLowByte:  return '0;
         DigitsHighByte: return '1;
         default:        return avp_pkg::byte_type'($urandom_range(255));
      endcase
   endfunction

   function automatic digit_mode_type random_mode();
      return ($urandom_range(99) < 80) ? DigitsDecimal : DigitsWild;
   endfunction

   // A frame is exactly one window long: anchor, a random separator, the
   // field itself and random filler after it.
   function automatic frame_type build_frame(form_type form, digit_mode_type mode);
      frame_type f;
      foreach (f[i]) f[i] = avp_pkg::byte_type'($urandom_range(255));
      if (form == FormVoltLong || form == FormVoltShort) begin
         f[0] = avp_pkg::AsciiUpperV;
         f[1] = avp_pkg::AsciiLowerO;
      end else begin
         f[0] = avp_pkg::AsciiUpperP;
         f[1] = avp_pkg::AsciiLowerS;
      end
      case (form)
         FormVoltLong: begin
            f[3] = pick_digit(mode);
            f[4] = pick_digit(mode);
            f[5] = avp_pkg::AsciiDot;
            f[6] = pick_digit(mode);
            f[7] = pick_digit(mode);
            f[8] = avp_pkg::AsciiSpace;
         end
         FormVoltShort: begin
            f[3] = pick_digit(mode);
            f[4] = avp_pkg::AsciiDot;
            f[5] = pick_digit(mode);
            f[6] = pick_digit(mode);
            f[7] = avp_pkg::AsciiSpace;
         end
         FormPowerTwo: begin
            f[3] = pick_digit(mode);
            f[4] = pick_digit(mode);
            f[5] = avp_pkg::AsciiDot;
            f[6] = pick_digit(mode);
            f[7] = pick_digit(mode);
            f[8] = avp_pkg::AsciiCr;
            f[9] = avp_pkg::AsciiLf;
         end
         FormPowerThree: begin
            f[3]  = pick_digit(mode);
            f[4]  = pick_digit(mode);
            f[5]  = pick_digit(mode);
            f[6]  = avp_pkg::AsciiDot;
            f[7]  = pick_digit(mode);
            f[8]  = pick_digit(mode);
            f[9]  = avp_pkg::AsciiCr;
            f[10] = avp_pkg::AsciiLf;
         end
         default: begin
            f[3] = pick_digit(mode);
            f[4] = avp_pkg::AsciiDot;
            f[5] = pick_digit(mode);
            f[6] = pick_digit(mode);
            f[7] = avp_pkg::AsciiCr;
            f[8] = avp_pkg::AsciiLf;
         end
      endcase
      return f;
   endfunction

   // Inserts a random number of idle cycles before the next transaction.
   // Valid is lowered only when a gap is actually taken, so it never gets
   // two assignments in the same time step.
   task automatic idle_gap();
      while (idle_on && $urandom_range(99) < IdlePercent) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_byte(input avp_pkg::byte_type rx, input logic last);
      idle_gap();
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= rx;
      req_ch.burst_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      sent_bytes++;
      idle_on = !(sent_bytes >= QuietFrom && sent_bytes < QuietTo);
   endtask

   // Sends the first count bytes of a frame; the burst mark, if asked for,
   // goes on the last byte sent.
   task automatic send_frame(input frame_type f, input int unsigned count,
                             input logic last);
      for (int unsigned i = 0; i < count; i++) begin
         send_byte(f[i], last && (i == count - 1));
      end
   endtask

   initial begin
      frame_type   f;
      int unsigned pick;
      int unsigned stop_at;

      board = new();
      req_ch.valid     <= 1'b0;
      req_ch.rx_byte   <= '0;
      req_ch.burst_end <= 1'b0;
      reset            <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames, each closed by a burst mark so that none of them
      // sees bytes of its neighbor. The first one also shows that nothing is
      // evaluated before the window has filled.
      send_frame(build_frame(FormVoltLong, DigitsDecimal), avp_pkg::WinLen, 1'b1);
      send_frame(build_frame(FormVoltShort, DigitsDecimal), avp_pkg::WinLen, 1'b1);
      send_frame(build_frame(FormPowerTwo, DigitsDecimal), avp_pkg::WinLen, 1'b1);
      send_frame(build_frame(FormPowerOne, DigitsDecimal), avp_pkg::WinLen, 1'b1);

      // Largest and smallest possible values: every digit slot of the
      // longest power form holds the all-ones byte, then the all-zero byte.
      send_frame(build_frame(FormPowerThree, DigitsHighByte), avp_pkg::WinLen, 1'b1);
      send_frame(build_frame(FormPowerThree, DigitsLowByte), avp_pkg::WinLen, 1'b1);

      // Both voltage forms fit at once; only the long one may be taken.
      f = build_frame(FormVoltLong, DigitsDecimal);
      f[4] = avp_pkg::AsciiDot;
      f[7] = avp_pkg::AsciiSpace;
      send_frame(f, avp_pkg::WinLen, 1'b1);

      // The three-digit and the one-digit power forms both fit.
      f = build_frame(FormPowerThree, DigitsDecimal);
      f[4] = avp_pkg::AsciiDot;
      f[7] = avp_pkg::AsciiCr;
      f[8] = avp_pkg::AsciiLf;
      send_frame(f, avp_pkg::WinLen, 1'b1);

      // A valid voltage field whose window is cut short by the burst end
      // must never be evaluated.
      send_frame(build_frame(FormVoltLong, DigitsDecimal), avp_pkg::WinLen - 2, 1'b1);

      // Random part: mostly well-formed frames with random content, often
      // back to back so that later frames also slide through earlier
      // filler, mixed with loose noise bytes and damaged or cut frames.
      stop_at = sent_bytes + RandomBytes;
      while (sent_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            f = build_frame(form_type'($urandom_range(4)), random_mode());
            send_frame(f, avp_pkg::WinLen, $urandom_range(99) < 20);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(avp_pkg::byte_type'($urandom_range(255)),
                         $urandom_range(99) < 5);
            end
         end else begin
            f = build_frame(form_type'($urandom_range(4)), random_mode());
            if ($urandom_range(1) == 1) begin
               f[$urandom_range(2, avp_pkg::WinLen - 1)] =
                  avp_pkg::byte_type'($urandom_range(255));
               send_frame(f, avp_pkg::WinLen, $urandom_range(99) < 20);
            end else begin
               send_frame(f, $urandom_range(2, avp_pkg::WinLen - 1), 1'b1);
            end
         end
      end
      req_ch.valid <= 1'b0;

      // Wait for every queued field to come back, then keep watching for stray results.
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
